// ===== hw/rtl/fas_pkg.sv =====
package fas_pkg;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OP_W       = 2;
    localparam int STEP_W     = 16;
    localparam int KIND_W     = 3;
    localparam int REG_W      = 16;
    localparam int PEAK_W     = 13;
    localparam int ELAPSED_W  = 32;
    localparam int PHASE_W    = 2;

    localparam logic [PEAK_W-1:0] PEAK_RESET = 13'd2048;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK  = 3'd4;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

    // Fade kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OUT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INOUT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CROSS = 3'd4;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 2'd0,
        PH_RISE = 2'd1,
        PH_MID  = 2'd2,
        PH_FALL = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_MUL  = 2'd1,
        SQ_DIV  = 2'd2,
        SQ_DONE = 2'd3
    } t_seq;

endpackage

// ===== hw/rtl/fas_div.sv =====
module fas_div #(
    parameter int DEN_W = 16,
    parameter int QUO_W = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DEN_W+QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic                   o_done,
    output logic [QUO_W-1:0]       o_quot
);
    // Restoring divider, one quotient bit per cycle.
    // Upper numerator bits must already be below the divisor.
    localparam int CW = $clog2(QUO_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [QUO_W-1:0] r_quo, n_quo;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // Trial subtract
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[DEN_W+QUO_W-1:QUO_W];
            n_quo  = i_num[QUO_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], w_ge};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath, no reset
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/fade_alpha_sequencer.sv =====
// Screen fade sequencer. Each request (tick, start, cancel or unknown op)
// gives one result with the cover alpha (Q with ALPHA_BITS fraction bits),
// the phase and the active flag after the request. Requests that need no
// division (start, cancel, unknown op, idle ticks, pause ticks and ramp-end
// ticks) go from acceptance straight to the done state, which loads their
// result into the output register. A tick inside a ramp first passes the
// multiply state, which loads the shared serial divider, then the divide
// state, in which the divider makes ALPHA_BITS + 1 quotient bits at one per
// cycle and the quotient is taken, and then the done state, which loads the
// output register. A new request is taken once the previous result has been
// loaded into the output register; a result still waiting there on a stalled
// receiver adds its wait to the next request's time. Durations are read from
// the configuration registers on each tick and are masked to the smaller of
// TIME_BITS and REG_W bits; elapsed time saturates at 32 bits.
module fade_alpha_sequencer #(
    parameter int ALPHA_BITS = 12,
    parameter int TIME_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fas_pkg::OP_W-1:0]       i_op,
    input  logic signed [fas_pkg::STEP_W-1:0] i_step_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ALPHA_BITS:0]            o_alpha,
    output logic [fas_pkg::PHASE_W-1:0]    o_phase,
    output logic                           o_active
);
    import fas_pkg::*;

    localparam int QW    = ALPHA_BITS + 1;
    localparam int DUR_W = (TIME_BITS < REG_W) ? TIME_BITS : REG_W;
    localparam int PW    = (QW > PEAK_W) ? QW : PEAK_W;
    localparam int NW    = DUR_W + QW;
    localparam logic [QW-1:0] ALPHA_ONE = QW'(1) << ALPHA_BITS;

    // Configuration
    logic [KIND_W-1:0] r_cfg_kind;
    logic [REG_W-1:0]  r_cfg_rise;
    logic [REG_W-1:0]  r_cfg_fall;
    logic [REG_W-1:0]  r_cfg_pause;
    logic [PEAK_W-1:0] r_cfg_peak;

    // Fade state
    t_seq              r_seq, n_seq;
    t_phase            r_phase, n_phase;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [QW-1:0]     r_alpha, n_alpha;
    logic              r_pause_seen, n_pause_seen;
    logic              r_hold, n_hold;

    // Operands held for the divide
    logic [DUR_W-1:0]  r_m, n_m;
    logic [DUR_W-1:0]  r_den, n_den;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [QW-1:0]     r_out_alpha, n_out_alpha;
    t_phase            r_out_phase, n_out_phase;

    logic              w_accept;
    logic [STEP_W-1:0] w_step;
    logic [ELAPSED_W:0] w_sum;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [DUR_W-1:0]  w_rise_dur, w_fall_dur, w_pause;
    logic [PW-1:0]     w_peak_cfg;
    logic [QW-1:0]     w_peak;
    logic              w_rise_run, w_fall_run;
    logic [NW-1:0]     w_prod;
    logic              w_div_start;
    logic              w_div_done;
    logic [QW-1:0]     w_quot;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_kind  <= KIND_NONE;
            r_cfg_rise  <= '0;
            r_cfg_fall  <= '0;
            r_cfg_pause <= '0;
            r_cfg_peak  <= PEAK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KIND:  r_cfg_kind  <= i_cfg_data[KIND_W-1:0];
                CFG_RISE:  r_cfg_rise  <= i_cfg_data[REG_W-1:0];
                CFG_FALL:  r_cfg_fall  <= i_cfg_data[REG_W-1:0];
                CFG_PAUSE: r_cfg_pause <= i_cfg_data[REG_W-1:0];
                CFG_PEAK:  r_cfg_peak  <= i_cfg_data[PEAK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_seq == SQ_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Step clamp and saturating elapsed time
    assign w_step    = i_step_time[STEP_W-1] ? '0 : {1'b0, i_step_time[STEP_W-2:0]};
    assign w_sum     = {1'b0, r_elapsed} + (ELAPSED_W+1)'(w_step);
    assign w_elapsed = w_sum[ELAPSED_W] ? '1 : w_sum[ELAPSED_W-1:0];

    assign w_rise_dur = r_cfg_rise[DUR_W-1:0];
    assign w_fall_dur = r_cfg_fall[DUR_W-1:0];
    assign w_pause    = r_cfg_pause[DUR_W-1:0];

    // Peak level: crossfade uses its own level, clamped to full
    assign w_peak_cfg = PW'(r_cfg_peak);
    assign w_peak = (r_kind == KIND_CROSS && w_peak_cfg < PW'(ALPHA_ONE))
                  ? QW'(w_peak_cfg) : ALPHA_ONE;

    assign w_rise_run = (w_rise_dur != '0) && (w_elapsed < ELAPSED_W'(w_rise_dur));
    assign w_fall_run = (w_fall_dur != '0) && (w_elapsed < ELAPSED_W'(w_fall_dur));

    // Multiply ahead of the divider
    assign w_prod      = NW'(r_m) * NW'(w_peak);
    assign w_div_start = (r_seq == SQ_MUL);

    fas_div #(
        .DEN_W (DUR_W),
        .QUO_W (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Sequencer and fade state update
    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_elapsed    = r_elapsed;
        n_alpha      = r_alpha;
        n_pause_seen = r_pause_seen;
        n_hold       = r_hold;
        n_m          = r_m;
        n_den        = r_den;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_alpha  = r_out_alpha;
        n_out_phase  = r_out_phase;

        case (r_seq)
            SQ_IDLE: begin
                if (w_accept) begin
                    n_seq = SQ_DONE;
                    case (i_op)
                        OP_START: begin
                            n_elapsed    = '0;
                            n_pause_seen = 1'b0;
                            n_hold       = 1'b0;
                            n_kind       = r_cfg_kind;
                            n_alpha      = '0;
                            n_phase      = PH_RISE;
                            if (r_cfg_kind == KIND_IN) begin
                                n_phase = PH_FALL;
                                n_alpha = ALPHA_ONE;
                            end else if (!(r_cfg_kind == KIND_OUT ||
                                           r_cfg_kind == KIND_INOUT ||
                                           r_cfg_kind == KIND_CROSS)) begin
                                n_phase = PH_IDLE;
                                n_kind  = KIND_NONE;
                            end
                        end
                        OP_CANCEL: begin
                            n_phase      = PH_IDLE;
                            n_kind       = KIND_NONE;
                            n_alpha      = '0;
                            n_elapsed    = '0;
                            n_pause_seen = 1'b0;
                            n_hold       = 1'b0;
                        end
                        OP_TICK: begin
                            if (r_phase != PH_IDLE) begin
                                n_elapsed = w_elapsed;
                            end
                            case (r_phase)
                                PH_RISE: begin
                                    if (w_rise_run) begin
                                        n_m   = w_elapsed[DUR_W-1:0];
                                        n_den = w_rise_dur;
                                        n_seq = SQ_MUL;
                                    end else begin
                                        n_alpha = w_peak;
                                        if (r_kind == KIND_OUT ||
                                            r_kind == KIND_INOUT) begin
                                            n_phase      = PH_MID;
                                            n_elapsed    = '0;
                                            n_pause_seen = 1'b0;
                                            n_hold       = (r_kind == KIND_OUT);
                                        end else if (r_kind == KIND_CROSS) begin
                                            n_phase   = PH_FALL;
                                            n_elapsed = '0;
                                        end
                                    end
                                end
                                PH_MID: begin
                                    if (r_hold) begin
                                        n_alpha = ALPHA_ONE;
                                    end else begin
                                        n_alpha = w_peak;
                                        if (!r_pause_seen) begin
                                            n_pause_seen = 1'b1;
                                        end else if (w_elapsed >=
                                                     ELAPSED_W'(w_pause)) begin
                                            n_phase   = PH_FALL;
                                            n_elapsed = '0;
                                        end
                                    end
                                end
                                PH_FALL: begin
                                    if (w_fall_run) begin
                                        n_m   = w_fall_dur - w_elapsed[DUR_W-1:0];
                                        n_den = w_fall_dur;
                                        n_seq = SQ_MUL;
                                    end else begin
                                        n_phase      = PH_IDLE;
                                        n_kind       = KIND_NONE;
                                        n_alpha      = '0;
                                        n_elapsed    = '0;
                                        n_pause_seen = 1'b0;
                                        n_hold       = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            SQ_MUL: begin
                n_seq = SQ_DIV;
            end
            SQ_DIV: begin
                if (w_div_done) begin
                    n_alpha = w_quot;
                    n_seq   = SQ_DONE;
                end
            end
            SQ_DONE: begin
                // load the result once the output slot is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_alpha = r_alpha;
                    n_out_phase = r_phase;
                    n_seq       = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SQ_IDLE;
            r_phase      <= PH_IDLE;
            r_kind       <= KIND_NONE;
            r_elapsed    <= '0;
            r_alpha      <= '0;
            r_pause_seen <= 1'b0;
            r_hold       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_elapsed    <= n_elapsed;
            r_alpha      <= n_alpha;
            r_pause_seen <= n_pause_seen;
            r_hold       <= n_hold;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_m         <= n_m;
        r_den       <= n_den;
        r_out_alpha <= n_out_alpha;
        r_out_phase <= n_out_phase;
    end

    assign o_out_valid = r_out_valid;
    assign o_alpha     = r_out_alpha;
    assign o_phase     = r_out_phase;
    assign o_active    = (r_out_phase != PH_IDLE);

    // Checks
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alpha <= ALPHA_ONE))
        else $error("alpha above full scale");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> (o_alpha == '0))
        else $error("idle result with non-zero alpha");

    a_div_done_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_seq == SQ_DIV))
        else $error("divider finished outside divide state");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request taken while another is in progress");

endmodule
